// File: rtl/sha_pkg.sv
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam int QueueDepth = 4;
  localparam int QueueAw = 2;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LengthOffset = 6'd56;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } core_state_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/sha_queue.sv
module sha_queue
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_full,
  input  in_beat_t wr_data,
  output logic     rd_valid,
  input  logic     rd_take,
  output in_beat_t rd_data
);

  in_beat_t slots [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0] count;
  logic push;
  logic pop;

  assign wr_full  = (count == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  // drop empty beats here: they change nothing
  assign push = wr_valid && !wr_full && (wr_data.has_byte || wr_data.last_byte);
  assign pop  = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QueueAw'(1);
      if (pop) rd_ptr <= rd_ptr + QueueAw'(1);
      count <= count + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + (QueueAw+1)'(1)))
    else $error("queue count slip");

endmodule

// File: rtl/sha_core.sv
module sha_core
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_take,
  input  in_beat_t  q_data,
  output logic      res_valid,
  input  logic      res_stall,
  output out_beat_t res
);

  core_state_t state;
  core_state_t state_next;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [31:0] pad_w [16];
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [5:0]  rnd;
  logic        final_blk;
  logic        len_pending;
  logic        tail_blk;
  logic        len_here;
  logic [2:0]  widx;
  logic [31:0] big0, big1, ch, mj, t1, t2, sg0, sg1, wnew, wcur;
  logic [31:0] wbyte;
  logic [7:0]  byte_val;
  logic        wr_byte;

  assign q_take = (state == ST_TAKE) && q_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_TAKE: begin
        if (q_valid) begin
          if (q_data.has_byte && fill == 6'd63) state_next = ST_ROUND;
          else if (q_data.last_byte) state_next = ST_PAD;
        end
      end
      ST_ROUND: if (rnd == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (!final_blk) state_next = ST_TAKE;
        else if (tail_blk) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_PAD: state_next = ST_ROUND;
      ST_EMIT: if (!res_stall && widx == 3'd7) state_next = ST_TAKE;
      default: state_next = ST_TAKE;
    endcase
  end

  // round datapath
  assign wcur = w[0];
  assign big1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
                {v[4][24:0], v[4][31:25]};
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + big1 + ch + round_k(rnd) + wcur;
  assign big0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
                {v[0][21:0], v[0][31:22]};
  assign mj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = big0 + mj;
  assign sg0  = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign sg1  = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^
                (w[14] >> 10);
  assign wnew = w[0] + sg0 + w[9] + sg1;

  // byte into the current schedule word
  assign wr_byte  = q_take && q_data.has_byte;
  assign byte_val = q_data.data_byte;
  always_comb begin
    wbyte = w[fill[5:2]];
    case (fill[1:0])
      2'd0: wbyte[31:24] = byte_val;
      2'd1: wbyte[23:16] = byte_val;
      2'd2: wbyte[15:8]  = byte_val;
      default: wbyte[7:0] = byte_val;
    endcase
  end

  // padded block: keep bytes below fill, mark at fill, zeros above, length if it fits
  assign len_here = len_pending || (fill < LengthOffset);
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      pad_w[j] = w[j];
      for (int b = 0; b < 4; b++) begin
        if (len_pending || 6'(4*j+b) > fill) pad_w[j][31-8*b -: 8] = 8'h00;
        else if (6'(4*j+b) == fill) pad_w[j][31-8*b -: 8] = PadMark;
      end
    end
    if (len_here) begin
      pad_w[14] = bits[63:32];
      pad_w[15] = bits[31:0];
    end
  end

  // outputs
  always_comb begin
    res_valid = (state == ST_EMIT);
    res.digest_word = h[widx];
    res.word_index  = widx;
    res.last_word   = (widx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) h[i] <= InitHash[255-32*i -: 32];
      fill <= '0;
      bits <= '0;
      rnd <= '0;
      final_blk <= 1'b0;
      len_pending <= 1'b0;
      tail_blk <= 1'b0;
      widx <= '0;
    end else begin
      case (state)
        ST_TAKE: begin
          if (wr_byte) begin
            w[fill[5:2]] <= wbyte;
            fill <= fill + 6'd1;
            bits <= bits + 64'd8;
          end
          if (q_take) begin
            final_blk <= q_data.last_byte;
            // load working vars on every take, ready for the rounds on a full block
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            rnd <= '0;
          end
        end
        ST_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          rnd <= rnd + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
        end
        ST_PAD: begin
          // load the padded block; owe a length block when the mark leaves no room
          for (int j = 0; j < 16; j++) w[j] <= pad_w[j];
          len_pending <= !len_here;
          tail_blk <= len_here;
          fill <= '0;
          final_blk <= 1'b1;
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          rnd <= '0;
        end
        ST_EMIT: begin
          if (!res_stall) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= InitHash[255-32*i -: 32];
              bits <= '0;
              fill <= '0;
              final_blk <= 1'b0;
              tail_blk <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && res_stall) |=> (state == ST_EMIT && $stable(widx)))
    else $error("digest word moved under stall");
  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (state == ST_TAKE)) else $error("beat taken while busy");
  a_round_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'd63) |=> (state == ST_ADD))
    else $error("round count slip");

endmodule

// File: rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream. Each input beat carries at most one message byte;
// last_byte closes the message, after which eight digest beats follow, word 0
// first, last_word on word 7. A beat with neither flag is dropped. Bytes go
// through a four-entry queue into the compression engine, which takes one byte
// per cycle while bytes are queued and a block is being collected, then runs
// the rounds and a final add on each full block, taking no bytes meanwhile.
// Closing a message costs one or two padded blocks plus eight digest beats,
// which out_stall can hold.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic     q_valid;
  logic     q_take;
  in_beat_t q_data;

  sha_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_full  (in_stall),
    .wr_data  (in_data),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_data)
  );

  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_data    (q_data),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (out_data)
  );

endmodule
